// File: src/rgbmx_pkg.sv
package rgbmx_pkg;

  // Matrix geometry and reset values
  localparam int          ROWS_DEF        = 8;
  localparam logic [15:0] ON_TICKS_RST    = 16'd1000;
  localparam logic [15:0] BLANK_TICKS_RST = 16'd50;
  localparam logic [7:0]  COLS_OFF        = 8'hff;

  // Item actions
  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_SET_PIXEL   = 3'd1,
    ACT_CLEAR_PIXEL = 3'd2,
    ACT_CLEAR_ALL   = 3'd3,
    ACT_SCROLL_UP   = 3'd4,
    ACT_SCROLL_DOWN = 3'd5
  } action_t;

  // Configuration register indexes (paddr[2])
  localparam logic REG_ON_TICKS    = 1'b0;
  localparam logic REG_BLANK_TICKS = 1'b1;

  // One row of the frame store, active low
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_row_t;

  localparam pix_row_t PIX_ROW_OFF = '{red: COLS_OFF, green: COLS_OFF, blue: COLS_OFF};

  // Input item
  typedef struct packed {
    logic [2:0] action;
    logic [2:0] row;
    logic [2:0] column;
    logic [2:0] color;
    logic [7:0] incoming_red;
    logic [7:0] incoming_green;
    logic [7:0] incoming_blue;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [7:0] row_drive;
    logic [7:0] red_columns;
    logic [7:0] green_columns;
    logic [7:0] blue_columns;
    logic       blanking;
  } result_t;

endpackage

// File: src/rgb_led_matrix_scan_framebuffer_core.sv
// The result for an item accepted at one edge is registered and is on result,
//   with done high, in the next cycle.
// Throughput: one item per cycle; busy is high only while rst is high.
// The receiver cannot stall: there is no ready input, and done is high for each accepted item.
// Reset (synchronous): frame store all ones (every pixel off), scan at row 0 in
//   the on phase, on_ticks 1000, blank_ticks 50.
module rgb_led_matrix_scan_framebuffer_core #(
  parameter int ROWS = rgbmx_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              start,
  output logic              busy,
  input  rgbmx_pkg::cmd_t   cmd,
  output logic              done,
  output rgbmx_pkg::result_t result,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import rgbmx_pkg::*;

  localparam int RowW = $clog2(ROWS);

  // State
  pix_row_t        store [ROWS];
  pix_row_t        store_next [ROWS];
  logic [RowW-1:0] scan_row;
  logic [RowW-1:0] scan_row_next;
  logic            scan_blank;
  logic            scan_blank_next;
  logic [15:0]     phase_ticks;
  logic [15:0]     phase_ticks_next;
  logic [15:0]     on_ticks;
  logic [15:0]     blank_ticks;

  logic            accept;
  logic            row_ok;
  logic [RowW-1:0] wr_row;
  logic [7:0]      col_bit;
  pix_row_t        edit_row;
  pix_row_t        incoming;
  pix_row_t        disp_row;
  logic [15:0]     limit;
  logic [15:0]     ticks_inc;
  result_t         result_next;

  assign busy   = rst;
  assign accept = start && !busy;
  assign pready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      on_ticks    <= ON_TICKS_RST;
      blank_ticks <= BLANK_TICKS_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_ON_TICKS:    on_ticks    <= pwdata[15:0];
        REG_BLANK_TICKS: blank_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ON_TICKS:    prdata = {16'd0, on_ticks};
      REG_BLANK_TICKS: prdata = {16'd0, blank_ticks};
      default:         prdata = 32'd0;
    endcase
  end

  // Pixel edit: clear the pixel in all colours, then light the masked ones
  assign row_ok   = int'(cmd.row) < ROWS;
  assign wr_row   = RowW'(cmd.row);
  assign col_bit  = 8'd1 << cmd.column;
  assign incoming = '{red: cmd.incoming_red, green: cmd.incoming_green,
                      blue: cmd.incoming_blue};

  always_comb begin
    edit_row       = store[wr_row];
    edit_row.red   = edit_row.red   | col_bit;
    edit_row.green = edit_row.green | col_bit;
    edit_row.blue  = edit_row.blue  | col_bit;
    if (cmd.action == ACT_SET_PIXEL) begin
      if (cmd.color[0]) edit_row.red   = edit_row.red   & ~col_bit;
      if (cmd.color[1]) edit_row.green = edit_row.green & ~col_bit;
      if (cmd.color[2]) edit_row.blue  = edit_row.blue  & ~col_bit;
    end
  end

  // Next frame store
  always_comb begin
    for (int i = 0; i < ROWS; i++) store_next[i] = store[i];
    case (cmd.action)
      ACT_SET_PIXEL, ACT_CLEAR_PIXEL: begin
        if (row_ok) store_next[wr_row] = edit_row;
      end
      ACT_CLEAR_ALL: begin
        for (int i = 0; i < ROWS; i++) store_next[i] = PIX_ROW_OFF;
      end
      ACT_SCROLL_UP: begin
        for (int i = 0; i < ROWS - 1; i++) store_next[i] = store[i + 1];
        store_next[ROWS - 1] = incoming;
      end
      ACT_SCROLL_DOWN: begin
        for (int i = 1; i < ROWS; i++) store_next[i] = store[i - 1];
        store_next[0] = incoming;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) store[i] <= PIX_ROW_OFF;
    end else if (accept) begin
      for (int i = 0; i < ROWS; i++) store[i] <= store_next[i];
    end
  end

  // Scan advance on a tick; a zero length counts as one
  always_comb begin
    limit            = scan_blank ? blank_ticks : on_ticks;
    if (limit == 16'd0) limit = 16'd1;
    ticks_inc        = phase_ticks + 16'd1;
    phase_ticks_next = ticks_inc;
    scan_blank_next  = scan_blank;
    scan_row_next    = scan_row;
    if (ticks_inc >= limit) begin
      phase_ticks_next = 16'd0;
      scan_blank_next  = !scan_blank;
      if (scan_blank) begin
        scan_row_next = (scan_row == RowW'(ROWS - 1)) ? '0 : scan_row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row    <= '0;
      scan_blank  <= 1'b0;
      phase_ticks <= 16'd0;
    end else if (accept && cmd.action == ACT_TICK) begin
      scan_row    <= scan_row_next;
      scan_blank  <= scan_blank_next;
      phase_ticks <= phase_ticks_next;
    end
  end

  // Drive shown for this item: scan state before the tick, store after the edit.
  // Shifting an 8-bit one past bit seven leaves zero for rows 8 and up.
  always_comb begin
    disp_row              = store_next[scan_row];
    result_next.row_drive = 8'd1 << scan_row;
    if (scan_blank) begin
      result_next.red_columns   = COLS_OFF;
      result_next.green_columns = COLS_OFF;
      result_next.blue_columns  = COLS_OFF;
      result_next.blanking      = 1'b1;
    end else begin
      result_next.red_columns   = disp_row.red;
      result_next.green_columns = disp_row.green;
      result_next.blue_columns  = disp_row.blue;
      result_next.blanking      = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

// File: src/rgbmx_checker.sv
module rgbmx_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input rgbmx_pkg::result_t result,
  input logic               done
);
  import rgbmx_pkg::*;

  // Every accepted item gives a result on the next cycle
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted item gave no result");

  // No result without an item accepted the cycle before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without an accepted item");

  // Blank phase drives every column off
  a_blank_off: assert property (@(posedge clk) disable iff (rst)
    (done && result.blanking) |->
      (result.red_columns == COLS_OFF && result.green_columns == COLS_OFF &&
       result.blue_columns == COLS_OFF))
    else $error("columns lit during blanking");

  // At most one row driven
  a_row_onehot: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0(result.row_drive))
    else $error("more than one row driven");

endmodule

bind rgb_led_matrix_scan_framebuffer_core rgbmx_checker u_rgbmx_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .result(result),
  .done  (done)
);

// File: tb/sv/tb_rgb_led_matrix_scan_framebuffer_core.sv
module tb_rgb_led_matrix_scan_framebuffer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbmx_pkg::*;

  localparam int NROWS = ROWS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED_7 = 3'd7;
  localparam logic [2:0] ADDR_ON_TICKS = {REG_ON_TICKS, 2'b00};
  localparam logic [2:0] ADDR_BLANK_TICKS = {REG_BLANK_TICKS, 2'b00};
  localparam result_t ROW0_DARK = {8'h01, COLS_OFF, COLS_OFF, COLS_OFF, 1'b0};

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = '0;
  logic        done;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rgb_led_matrix_scan_framebuffer_core dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .cmd(cmd), .done(done), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicted scan and frame store state
  pix_row_t    fb_row [NROWS];
  int          scan_row;
  bit          scan_blank;
  logic [15:0] phase_cnt;
  logic [15:0] on_len;
  logic [15:0] blank_len;

  result_t drive_q [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_cfg = 0;
  int cyc = 0;

  typedef struct {
    cmd_t    c;
    bit      typed;
    result_t want;
  } dir_row_t;
  dir_row_t dir_tab [$];

  function automatic result_t current_drive();
    result_t d;
    d.row_drive = (scan_row < 8) ? 8'(8'h01 << scan_row) : 8'h00;
    if (scan_blank) begin
      d.red_columns   = COLS_OFF;
      d.green_columns = COLS_OFF;
      d.blue_columns  = COLS_OFF;
      d.blanking      = 1'b1;
    end else begin
      d.red_columns   = fb_row[scan_row].red;
      d.green_columns = fb_row[scan_row].green;
      d.blue_columns  = fb_row[scan_row].blue;
      d.blanking      = 1'b0;
    end
    return d;
  endfunction

  // Drive seen during the item, and the state it leaves behind
  function automatic result_t predict_drive(cmd_t c);
    result_t     d;
    logic [15:0] lim;
    logic [7:0]  m;
    m = 8'(8'h01 << c.column);
    case (c.action)
      ACT_TICK: begin
        d = current_drive();
        lim = scan_blank ? blank_len : on_len;
        if (lim == 16'd0) lim = 16'd1;   // zero length acts as one
        phase_cnt = phase_cnt + 16'd1;
        if (phase_cnt >= lim) begin
          phase_cnt = '0;
          if (scan_blank) scan_row = (scan_row + 1) % NROWS;
          scan_blank = !scan_blank;
        end
        return d;
      end
      ACT_SET_PIXEL, ACT_CLEAR_PIXEL: begin
        if (c.row < NROWS) begin
          fb_row[c.row].red   |= m;
          fb_row[c.row].green |= m;
          fb_row[c.row].blue  |= m;
          if (c.action == ACT_SET_PIXEL) begin
            if (c.color[0]) fb_row[c.row].red   &= ~m;
            if (c.color[1]) fb_row[c.row].green &= ~m;
            if (c.color[2]) fb_row[c.row].blue  &= ~m;
          end
        end
      end
      ACT_CLEAR_ALL: begin
        for (int i = 0; i < NROWS; i++) fb_row[i] = PIX_ROW_OFF;
      end
      ACT_SCROLL_UP: begin
        for (int i = 0; i < NROWS - 1; i++) fb_row[i] = fb_row[i + 1];
        fb_row[NROWS - 1] = {c.incoming_red, c.incoming_green, c.incoming_blue};
      end
      ACT_SCROLL_DOWN: begin
        for (int i = NROWS - 1; i > 0; i--) fb_row[i] = fb_row[i - 1];
        fb_row[0] = {c.incoming_red, c.incoming_green, c.incoming_blue};
      end
      default: ;   // unused actions leave everything alone
    endcase
    return current_drive();
  endfunction

  function automatic cmd_t cmd_of(logic [2:0] a, logic [2:0] r, logic [2:0] col,
                                  logic [2:0] clr, logic [7:0] ir, logic [7:0] ig,
                                  logic [7:0] ib);
    cmd_t c;
    c.action = a;
    c.row = r;
    c.column = col;
    c.color = clr;
    c.incoming_red = ir;
    c.incoming_green = ig;
    c.incoming_blue = ib;
    return c;
  endfunction

  // Mostly ticks and pixel writes, some scrolls, a few clears and unused codes
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   w;
    c = cmd_t'($bits(cmd_t)'({$urandom, $urandom}));
    w = $urandom_range(0, 99);
    if (w < 40)      c.action = ACT_TICK;
    else if (w < 62) c.action = ACT_SET_PIXEL;
    else if (w < 72) c.action = ACT_CLEAR_PIXEL;
    else if (w < 75) c.action = ACT_CLEAR_ALL;
    else if (w < 83) c.action = ACT_SCROLL_UP;
    else if (w < 91) c.action = ACT_SCROLL_DOWN;
    else             c.action = (w < 96) ? ACT_UNUSED_6 : ACT_UNUSED_7;
    return c;
  endfunction

  task automatic add_row(input cmd_t c, input bit typed, input result_t want);
    dir_row_t e;
    e.c = c;
    e.typed = typed;
    e.want = want;
    dir_tab.push_back(e);
  endtask

  // Offer one item after a random gap; start stays high across back-to-back items
  task automatic send_item(input cmd_t c, input bit typed, input result_t want);
    int      gap;
    result_t p;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_drive(c);
    drive_q.push_back(typed ? want : p);
    n_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
  endtask

  task automatic read_reg(input logic [2:0] addr, input logic [15:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'h0000, want}) begin
      $display("%0t: register %0d readback expected %h got %h",
               $time, addr, {16'h0000, want}, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == REG_ON_TICKS) on_len = val;
    else blank_len = val;
    n_cfg++;
    psel <= 1'b0;
    penable <= 1'b0;
    read_reg(addr, val);
  endtask

  task automatic set_lengths(input logic [15:0] on_v, input logic [15:0] blank_v);
    drain();
    write_reg(ADDR_ON_TICKS, on_v);
    write_reg(ADDR_BLANK_TICKS, blank_v);
  endtask

  task automatic cmp(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      errors++;
    end
  endtask

  // Result checker: every strobe must match the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        result_t e;
        e = drive_q.pop_front();
        cmp("row_drive", e.row_drive, result.row_drive);
        cmp("red_columns", e.red_columns, result.red_columns);
        cmp("green_columns", e.green_columns, result.green_columns);
        cmp("blue_columns", e.blue_columns, result.blue_columns);
        cmp("blanking", 8'(e.blanking), 8'(result.blanking));
        n_results++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  logic [15:0] on_set    [6] = '{16'd1, 16'd0, 16'd65535, 16'd3, 16'd1, 16'd5};
  logic [15:0] blank_set [6] = '{16'd1, 16'd0, 16'd65535, 16'd2, 16'd4, 16'd1};

  initial begin
    for (int i = 0; i < NROWS; i++) fb_row[i] = PIX_ROW_OFF;
    scan_row = 0;
    scan_blank = 1'b0;
    phase_cnt = '0;
    on_len = ON_TICKS_RST;
    blank_len = BLANK_TICKS_RST;

    // Directed items at the reset lengths: the scan stays on row 0, on phase
    add_row(cmd_of(ACT_TICK, 3'd0, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00), 1, ROW0_DARK);
    add_row(cmd_of(ACT_SET_PIXEL, 3'd0, 3'd0, 3'd7, 8'h00, 8'h00, 8'h00), 1,
            {8'h01, 8'hfe, 8'hfe, 8'hfe, 1'b0});
    add_row(cmd_of(ACT_SET_PIXEL, 3'd0, 3'd7, 3'd1, 8'hff, 8'hff, 8'hff), 0, '0);
    add_row(cmd_of(ACT_SET_PIXEL, 3'd7, 3'd3, 3'd2, 8'h00, 8'h00, 8'h00), 0, '0);
    add_row(cmd_of(ACT_SET_PIXEL, 3'd3, 3'd5, 3'd4, 8'h00, 8'h00, 8'h00), 0, '0);
    add_row(cmd_of(ACT_SET_PIXEL, 3'd0, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00), 0, '0);
    add_row(cmd_of(ACT_CLEAR_PIXEL, 3'd0, 3'd7, 3'd7, 8'h00, 8'h00, 8'h00), 0, '0);
    add_row(cmd_of(ACT_SET_PIXEL, 3'd1, 3'd1, 3'd3, 8'h00, 8'h00, 8'h00), 0, '0);
    add_row(cmd_of(ACT_UNUSED_6, 3'd7, 3'd7, 3'd7, 8'hff, 8'hff, 8'hff), 0, '0);
    add_row(cmd_of(ACT_UNUSED_7, 3'd0, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00), 0, '0);
    add_row(cmd_of(ACT_SCROLL_UP, 3'd0, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00), 0, '0);
    add_row(cmd_of(ACT_SCROLL_UP, 3'd7, 3'd7, 3'd7, 8'hff, 8'ha5, 8'h5a), 0, '0);
    add_row(cmd_of(ACT_SCROLL_DOWN, 3'd0, 3'd0, 3'd0, 8'h12, 8'h34, 8'h56), 1,
            {8'h01, 8'h12, 8'h34, 8'h56, 1'b0});
    add_row(cmd_of(ACT_SCROLL_DOWN, 3'd7, 3'd7, 3'd7, 8'h00, 8'h00, 8'h00), 1,
            {8'h01, 8'h00, 8'h00, 8'h00, 1'b0});
    add_row(cmd_of(ACT_CLEAR_PIXEL, 3'd7, 3'd7, 3'd7, 8'hff, 8'hff, 8'hff), 0, '0);
    add_row(cmd_of(ACT_CLEAR_ALL, 3'd5, 3'd2, 3'd6, 8'h00, 8'h00, 8'h00), 1, ROW0_DARK);
    add_row(cmd_of(ACT_SET_PIXEL, 3'd0, 3'd7, 3'd7, 8'hff, 8'hff, 8'hff), 0, '0);
    add_row(cmd_of(ACT_TICK, 3'd7, 3'd7, 3'd7, 8'hff, 8'hff, 8'hff), 0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register values after reset
    read_reg(ADDR_ON_TICKS, ON_TICKS_RST);
    read_reg(ADDR_BLANK_TICKS, BLANK_TICKS_RST);
    @(posedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].want);
    repeat (100) send_item(rand_cmd(), 0, '0);

    // Lengths from the shortest (and zero) to the longest
    for (int k = 0; k < 6; k++) begin
      set_lengths(on_set[k], blank_set[k]);
      repeat (80) send_item(rand_cmd(), 0, '0);
    end

    // Shorten the phase after it has already run past the new length
    set_lengths(16'd20, 16'd20);
    repeat (12) send_item(cmd_of(ACT_TICK, 3'd0, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00), 0, '0);
    set_lengths(16'd2, 16'd2);
    repeat (100) send_item(rand_cmd(), 0, '0);

    drain();
    repeat (3) @(posedge clk);
    $display("Sent %0d items, checked %0d results, %0d register writes", n_items,
             n_results, n_cfg);
    $display("Scan lengths from zero to 65535, pixel edits, scrolls and unused codes");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: rgb_led_matrix_scan_framebuffer_core.f
src/rgbmx_pkg.sv
src/rgb_led_matrix_scan_framebuffer_core.sv
src/rgbmx_checker.sv
tb/sv/tb_rgb_led_matrix_scan_framebuffer_core.sv
